/* sv/idw_pkg.sv */
`timescale 1ns / 1ps
package idw_pkg;

  localparam int CoordW = 32;
  localparam int ValW = 32;
  localparam int DsqW = 64;
  localparam int WgtW = 25;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_INTERP  = 3'd0,
    ST_EXACT   = 3'd1,
    ST_NODATA  = 3'd2,
    ST_STORED  = 3'd3,
    ST_FULL    = 3'd4,
    ST_CLEARED = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CFG_POWER  = 2'd0,
    CFG_RADIUS = 2'd1,
    CFG_LIMIT  = 2'd2
  } cfg_idx_t;

  localparam logic [31:0] NODATA_Q16 = 32'hD8F10000;
  localparam logic [11:0] POWER_RST = 12'd512;
  localparam logic [30:0] RADIUS_RST = 31'd0;
  localparam logic [4:0] LIMIT_RST = 5'd12;

  typedef struct packed {
    logic [1:0] action;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] sample_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [2:0] status;
  } out_beat_t;

  // controller to datapath
  typedef struct packed {
    logic latch_q;
    logic write_pt;
    logic clear_cnt;
    logic scan_start;
    logic scan_step;
    logic wt_start;
    logic wt_step;
    logic div_start;
    logic div_step;
    logic fin_exact;
    logic fin_interp;
    logic fin_nodata;
    logic fin_simple;
  } idw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic scan_done;
    logic any_kept;
    logic exact;
    logic wt_done;
    logic div_done;
  } idw_sts_t;

  // Q16 log2 approximation of f correction term
  function automatic logic [15:0] log_corr(input logic [15:0] f);
    logic [32:0] p;
    logic [31:0] t;
    begin
      p = {17'd0, f} * (33'd65536 - {17'd0, f});
      t = {16'd0, p[31:16]} * 32'd22528;
      log_corr = t[31:16];
    end
  endfunction

endpackage

/* sv/idw_ctrl.sv */
`timescale 1ns / 1ps
module idw_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  logic [1:0] in_action,
  input  logic out_free,
  input  idw_pkg::idw_sts_t sts,
  output idw_pkg::idw_cmd_t cmd,
  output logic busy
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_SCAN, S_WEIGHT, S_DIV, S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.latch_q = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (out_free) begin
          unique case (idw_pkg::action_t'(in_action))
            idw_pkg::ACT_CLEAR: begin
              cmd.clear_cnt = 1'b1;
              cmd.fin_simple = 1'b1;
              state_nxt = S_IDLE;
            end
            idw_pkg::ACT_LOAD: begin
              cmd.write_pt = ~sts.full;
              cmd.fin_simple = 1'b1;
              state_nxt = S_IDLE;
            end
            idw_pkg::ACT_QUERY: begin
              cmd.scan_start = 1'b1;
              state_nxt = S_SCAN;
            end
            default: begin
              cmd.fin_nodata = 1'b1;
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          if (!sts.any_kept) begin
            cmd.fin_nodata = 1'b1;
            state_nxt = S_IDLE;
          end else if (sts.exact) begin
            cmd.fin_exact = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.wt_start = 1'b1;
            state_nxt = S_WEIGHT;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_WEIGHT: begin
        if (sts.wt_done) begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          cmd.wt_step = 1'b1;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_FINISH: begin
        cmd.fin_interp = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

/* sv/idw_dpath.sv */
`timescale 1ns / 1ps
module idw_dpath #(
  parameter int MAX_POINTS = 1024,
  parameter int MAX_NEIGHBORS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  idw_pkg::in_beat_t in_beat,
  input  logic [11:0] power_q8,
  input  logic [30:0] rad_lim,
  input  logic [4:0] neighbor_limit,
  input  idw_pkg::idw_cmd_t cmd,
  output idw_pkg::idw_sts_t sts,
  output logic [1:0] q_action,
  output logic fin_valid,
  output idw_pkg::out_beat_t fin_beat
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int NW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int KW = $clog2(MAX_NEIGHBORS + 1);

  // point memory
  logic [95:0] mem [MAX_POINTS];
  logic [95:0] rd_r;
  logic [CW-1:0] cnt_r;
  idw_pkg::in_beat_t q_r;

  // scan pipeline: addr -> read -> diff -> square -> insert
  logic [CW-1:0] rd_idx_r;
  logic v1_r, v2_r, v3_r;
  logic [31:0] val2_r, val3_r;
  logic [32:0] ax_r, ay_r;
  logic [63:0] sqx_r, sqy_r;

  logic [63:0] nd_r [MAX_NEIGHBORS];
  logic [31:0] nv_r [MAX_NEIGHBORS];
  logic [KW-1:0] kept_r;
  logic [KW-1:0] lim;
  logic [61:0] rsq;

  always_comb begin
    if (neighbor_limit == 5'd0) lim = KW'(1);
    else if ({27'd0, neighbor_limit} > MAX_NEIGHBORS) lim = KW'(MAX_NEIGHBORS);
    else lim = KW'(neighbor_limit);
  end
  assign rsq = {31'd0, rad_lim} * {31'd0, rad_lim};

  // memory write and read
  always_ff @(posedge clk) begin
    if (cmd.write_pt) begin
      mem[cnt_r[AW-1:0]] <= {q_r.coord_x, q_r.coord_y, q_r.sample_value};
    end
    rd_r <= mem[rd_idx_r[AW-1:0]];
  end

  // store count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.clear_cnt) begin
      cnt_r <= '0;
    end else if (cmd.write_pt) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_q) q_r <= in_beat;
  end
  assign q_action = q_r.action;
  assign sts.full = (cnt_r == CW'(MAX_POINTS));

  // squared distance, saturated
  logic [64:0] dsum;
  logic [63:0] dsq;
  assign dsum = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign dsq = dsum[64] ? '1 : dsum[63:0];

  logic in_rad;
  assign in_rad = (rad_lim == 31'd0) || (dsq <= {2'd0, rsq});

  logic rd_issue;
  assign rd_issue = cmd.scan_step && (rd_idx_r < cnt_r);

  logic signed [32:0] dx, dy;
  assign dx = 33'(signed'(q_r.coord_x)) - 33'(signed'(rd_r[95:64]));
  assign dy = 33'(signed'(q_r.coord_y)) - 33'(signed'(rd_r[63:32]));

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.scan_start) begin
      rd_idx_r <= '0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (cmd.scan_step) begin
      if (rd_issue) rd_idx_r <= rd_idx_r + CW'(1);
      v1_r <= rd_issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      ax_r <= dx[32] ? 33'(-dx) : 33'(dx);
      ay_r <= dy[32] ? 33'(-dy) : 33'(dy);
      val2_r <= rd_r[31:0];
      sqx_r <= 64'({31'd0, ax_r} * {31'd0, ax_r});
      sqy_r <= 64'({31'd0, ay_r} * {31'd0, ay_r});
      val3_r <= val2_r;
    end
  end

  // sorted insertion over the neighbor list, one candidate per cycle
  logic take;
  logic [KW-1:0] last;
  assign last = lim - KW'(1);
  assign take = v3_r && cmd.scan_step && in_rad &&
                ((kept_r < lim) || (dsq < nd_r[last[NW-1:0]]));

  logic [KW-1:0] fill;
  assign fill = (kept_r < lim) ? kept_r : last;

  always_ff @(posedge clk) begin
    if (take) begin
      for (int j = 0; j < MAX_NEIGHBORS; j++) begin
        if (KW'(j) <= fill) begin
          if (j > 0 && nd_r[(j > 0) ? j - 1 : 0] > dsq) begin
            nd_r[j] <= nd_r[(j > 0) ? j - 1 : 0];
            nv_r[j] <= nv_r[(j > 0) ? j - 1 : 0];
          end else if (j == 0 || !(nd_r[(j > 0) ? j - 1 : 0] > dsq)) begin
            if (j == 0 ? !(nd_r[0] > dsq) && kept_r != 0 : 1'b0) begin
              nd_r[j] <= nd_r[j];
            end else if (nd_r[j] > dsq || KW'(j) == fill) begin
              nd_r[j] <= dsq;
              nv_r[j] <= val3_r;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.scan_start) begin
      kept_r <= '0;
    end else if (take && kept_r < lim) begin
      kept_r <= kept_r + KW'(1);
    end
  end

  assign sts.scan_done = !v1_r && !v2_r && !v3_r && (rd_idx_r >= cnt_r) && !cmd.scan_start;
  assign sts.any_kept = (kept_r != '0);
  assign sts.exact = (nd_r[0] == 64'd0);

  // weight loop: one neighbor through a short fixed sequence of phases
  logic [NW-1:0] wi_r;
  logic [2:0] ph_r;
  logic [22:0] l0_r, li_r;
  logic [35:0] e_r;
  logic [idw_pkg::WgtW-1:0] w_r;
  logic signed [63:0] vsum_r;
  logic [idw_pkg::WgtW+NW:0] wsum_r;
  logic wdone_r;
  logic signed [56:0] prod_r;

  // log2 of a 64 bit value in Q16
  logic [63:0] lx;
  logic [5:0] le;
  logic [15:0] lf;
  logic [79:0] lsh;
  logic [22:0] lres;
  assign lx = nd_r[wi_r];
  always_comb begin
    le = '0;
    for (int b = 1; b < 64; b++) begin
      if (lx[b]) le = 6'(b);
    end
    lsh = {lx, 16'd0} >> le;
    lf = lsh[15:0];
    lres = {le, 16'd0} + 23'(lf) + 23'(idw_pkg::log_corr(lf));
  end

  logic [22:0] dl;
  logic [35:0] ep;
  assign dl = (li_r > l0_r) ? li_r - l0_r : 23'd0;
  assign ep = 36'(({13'd0, dl} * {24'd0, power_q8}) >> 9);

  logic [19:0] ip;
  logic [15:0] g, h;
  logic [16:0] m;
  logic [idw_pkg::WgtW-1:0] wcalc;
  logic [24:0] mq;
  assign ip = e_r[35:16];
  assign g = e_r[15:0];
  assign h = 16'(17'd65536 - {1'b0, g});
  always_comb begin
    m = 17'(18'd65536 + {2'd0, h} - {2'd0, idw_pkg::log_corr(h)});
    mq = {m, 8'd0};
    if (g == 16'd0) begin
      wcalc = (ip >= 20'd63) ? '0 : idw_pkg::WgtW'(25'h1000000 >> ip[5:0]);
    end else begin
      wcalc = (ip >= 20'd63) ? '0 : idw_pkg::WgtW'(mq >> (ip[5:0] + 6'd1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wt_start) begin
      wi_r <= '0;
      ph_r <= '0;
      vsum_r <= '0;
      wsum_r <= '0;
      wdone_r <= 1'b0;
    end else if (cmd.wt_step) begin
      unique case (ph_r)
        3'd0: begin
          l0_r <= lres;
          ph_r <= 3'd1;
        end
        3'd1: begin
          li_r <= lres;
          ph_r <= 3'd2;
        end
        3'd2: begin
          e_r <= ep;
          ph_r <= 3'd3;
        end
        3'd3: begin
          w_r <= wcalc;
          ph_r <= 3'd4;
        end
        3'd4: begin
          prod_r <= $signed({1'b0, w_r}) * $signed(nv_r[wi_r]);
          ph_r <= 3'd5;
        end
        3'd5: begin
          vsum_r <= vsum_r + 64'(prod_r);
          wsum_r <= wsum_r + (idw_pkg::WgtW + NW + 1)'(w_r);
          if (KW'(wi_r) + KW'(1) >= kept_r) begin
            wdone_r <= 1'b1;
          end else begin
            wi_r <= wi_r + NW'(1);
          end
          ph_r <= 3'd1;
        end
        default: ph_r <= '0;
      endcase
    end
  end
  // phase 0 reads the nearest entry: wi_r is zero then
  assign sts.wt_done = wdone_r;

  // restoring divider, one quotient bit per cycle
  localparam int QW = 64;
  logic [63:0] num_r, quo_r;
  logic [idw_pkg::WgtW+NW+1:0] rem_r;
  logic [6:0] dcnt_r;
  logic neg_r;
  logic [63:0] mag;
  assign mag = vsum_r[63] ? 64'(-vsum_r) : 64'(vsum_r);
  logic [idw_pkg::WgtW+NW+2:0] trial;
  assign trial = {rem_r, num_r[63]} - {2'd0, wsum_r};

  logic [64:0] numr;
  assign numr = {1'b0, mag} + {1'b0, 64'(wsum_r >> 1)};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      num_r <= numr[63:0];
      rem_r <= (idw_pkg::WgtW + NW + 2)'(numr[64]);
      quo_r <= '0;
      dcnt_r <= 7'(QW);
      neg_r <= vsum_r[63];
    end else if (cmd.div_step && dcnt_r != 7'd0) begin
      num_r <= {num_r[62:0], 1'b0};
      dcnt_r <= dcnt_r - 7'd1;
      if (!trial[idw_pkg::WgtW+NW+2]) begin
        rem_r <= trial[idw_pkg::WgtW+NW+1:0];
        quo_r <= {quo_r[62:0], 1'b1};
      end else begin
        rem_r <= {rem_r[idw_pkg::WgtW+NW:0], num_r[63]};
        quo_r <= {quo_r[62:0], 1'b0};
      end
    end
  end
  assign sts.div_done = (dcnt_r == 7'd0) && !cmd.div_start;

  // result assembly
  logic [31:0] interp;
  always_comb begin
    if (neg_r) begin
      interp = (quo_r > 64'h80000000) ? 32'h80000000 : 32'(-quo_r[31:0]);
    end else begin
      interp = (quo_r > 64'h7FFFFFFF) ? 32'h7FFFFFFF : quo_r[31:0];
    end
  end

  always_comb begin
    fin_valid = cmd.fin_exact | cmd.fin_interp | cmd.fin_nodata | cmd.fin_simple;
    fin_beat.result_value = '0;
    fin_beat.status = idw_pkg::ST_NODATA;
    if (cmd.fin_exact) begin
      fin_beat.result_value = nv_r[0];
      fin_beat.status = idw_pkg::ST_EXACT;
    end else if (cmd.fin_interp) begin
      fin_beat.result_value = interp;
      fin_beat.status = idw_pkg::ST_INTERP;
    end else if (cmd.fin_nodata) begin
      fin_beat.result_value = idw_pkg::NODATA_Q16;
      fin_beat.status = idw_pkg::ST_NODATA;
    end else if (cmd.fin_simple) begin
      if (q_r.action == idw_pkg::ACT_CLEAR) fin_beat.status = idw_pkg::ST_CLEARED;
      else if (sts.full) fin_beat.status = idw_pkg::ST_FULL;
      else fin_beat.status = idw_pkg::ST_STORED;
    end
  end

endmodule

/* sv/idw_knn_interpolator.sv */
`timescale 1ns / 1ps
// Channel  Dir  Handshake        Payload
// in_      in   in_valid/stall   idw_pkg::in_beat_t
// out_     out  out_valid/stall  idw_pkg::out_beat_t
// cfg_     in   cfg_we           index 2 bit, data 31 bit
// A clear or load finishes from decode; a query runs decode, scan over the N
// stored points, weights over the K kept neighbors, divide, finish and idle;
// an exact hit or an empty search finishes after the scan. Reset is
// synchronous; the point store has no reset.
// in_stall is high while an item is in work; a stalled result holds in the
// output register and keeps the next item waiting in decode.
module idw_knn_interpolator #(
  parameter int MAX_POINTS = 1024,
  parameter int MAX_NEIGHBORS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  idw_pkg::in_beat_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output idw_pkg::out_beat_t out_data,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [30:0] cfg_data
);

  logic [11:0] power_r;
  logic [30:0] radius_r;
  logic [4:0] limit_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_r <= idw_pkg::POWER_RST;
      radius_r <= idw_pkg::RADIUS_RST;
      limit_r <= idw_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        idw_pkg::CFG_POWER: power_r <= cfg_data[11:0];
        idw_pkg::CFG_RADIUS: radius_r <= cfg_data;
        idw_pkg::CFG_LIMIT: limit_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  idw_pkg::idw_cmd_t cmd;
  idw_pkg::idw_sts_t sts;
  logic busy, in_fire, out_free, fin_valid;
  logic [1:0] q_action;
  idw_pkg::out_beat_t fin_beat;

  assign in_stall = busy;
  assign in_fire = in_valid && !busy;
  assign out_free = !out_valid || !out_stall;

  idw_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_action(q_action),
    .out_free(out_free), .sts(sts), .cmd(cmd), .busy(busy)
  );

  idw_dpath #(.MAX_POINTS(MAX_POINTS), .MAX_NEIGHBORS(MAX_NEIGHBORS)) u_dpath (
    .clk(clk), .rst_n(rst_n), .in_beat(in_data), .power_q8(power_r),
    .rad_lim(radius_r), .neighbor_limit(limit_r), .cmd(cmd), .sts(sts),
    .q_action(q_action), .fin_valid(fin_valid), .fin_beat(fin_beat)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (fin_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (fin_valid) out_data <= fin_beat;
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> busy) else $error("accept did not start work");
  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    fin_valid |-> out_free) else $error("result overwrote a pending beat");
  a_one_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.fin_exact, cmd.fin_interp, cmd.fin_nodata, cmd.fin_simple}))
    else $error("multiple finish commands");
`endif

endmodule
